@@ hw/rtl/address_region_attributor_macros.svh @@
// ----------------------------------------------------------------------------
// address region attributor assertion macros
// shared concurrent assertion forms, clocked on clock and off during reset
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_ATTRIBUTOR_MACROS_SVH
`define ADDRESS_REGION_ATTRIBUTOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ARAT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ARAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/arat_pkg.sv @@
// ----------------------------------------------------------------------------
// arat_pkg
// table sizes, field widths and codes of the address region attributor
// ----------------------------------------------------------------------------
`default_nettype none

package arat_pkg;

   localparam int USER_ENTRIES   = 64;
   localparam int KERNEL_ENTRIES = 256;

   localparam int KIND_W  = 3;
   localparam int INDEX_W = 8;
   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 32;
   localparam int SRC_W   = 2;

   localparam int UIDX_W = (USER_ENTRIES > 1) ? $clog2(USER_ENTRIES) : 1;
   localparam int KIDX_W = (KERNEL_ENTRIES > 1) ? $clog2(KERNEL_ENTRIES) : 1;
   localparam int SCAN_MAX = (USER_ENTRIES > KERNEL_ENTRIES) ? USER_ENTRIES : KERNEL_ENTRIES;
   localparam int CNT_W = $clog2(SCAN_MAX + 1);
   localparam int WIDX_W0 = (UIDX_W > KIDX_W) ? UIDX_W : KIDX_W;
   localparam int WIDX_W = (WIDX_W0 > INDEX_W) ? WIDX_W0 : INDEX_W;

   localparam logic [KIND_W-1:0] KIND_CLR_USER    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLR_KERNEL  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WR_USER     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WR_KERNEL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOOKUP      = 3'd4;

   localparam logic [SRC_W-1:0] SRC_NONE   = 2'd0;
   localparam logic [SRC_W-1:0] SRC_USER   = 2'd1;
   localparam logic [SRC_W-1:0] SRC_KERNEL = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/arat_if.sv @@
// ----------------------------------------------------------------------------
// arat channel interfaces
// request and response valid/ready channels of the address region attributor
// ----------------------------------------------------------------------------
`default_nettype none

interface arat_req_if import arat_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [INDEX_W-1:0]  entry_index;
   logic [ADDR_W-1:0]   entry_base;
   logic [SIZE_W-1:0]   entry_size;
   logic [ADDR_W-1:0]   query_address;

   modport source (output valid, kind, entry_index, entry_base, entry_size, query_address,
                   input ready);
   modport sink   (input valid, kind, entry_index, entry_base, entry_size, query_address,
                   output ready);
endinterface

interface arat_rsp_if import arat_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SRC_W-1:0]    match_source;
   logic [INDEX_W-1:0]  match_index;
   logic [ADDR_W-1:0]   address_offset;

   modport source (output valid, match_source, match_index, address_offset, input ready);
   modport sink   (input valid, match_source, match_index, address_offset, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/address_region_attributor.sv @@
// ----------------------------------------------------------------------------
// address_region_attributor
// attributes a sampled address to a user or kernel image by scanning both
// tables with one shared subtract/compare unit
// ----------------------------------------------------------------------------
//  channel | dir | transfer when       | carries
//  req_if  | in  | valid & ready       | kind, entry_index, entry_base, entry_size, query_address
//  rsp_if  | out | valid & ready       | match_source, match_index, address_offset
//
//  clears and writes are taken in ST_IDLE; a lookup scans the user table, and
//  ST_UCHECK starts a kernel table scan only when no user entry matches
//  each scan is linear, one table entry per cycle through the single
//  subtract/compare unit behind the registered table read
//  reset is synchronous: clears valid bits, the sequencer and the response
//  req_if.ready is low during a lookup; a result waits in the output register
//  while the next request is taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "address_region_attributor_macros.svh"

module address_region_attributor import arat_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   arat_req_if.sink    req_if,
   arat_rsp_if.source  rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UCHECK,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // tables
   logic [ADDR_W-1:0] u_base_mem [USER_ENTRIES];
   logic [SIZE_W-1:0] u_size_mem [USER_ENTRIES];
   logic [ADDR_W-1:0] k_base_mem [KERNEL_ENTRIES];
   logic [USER_ENTRIES-1:0]   u_valid_ff;
   logic [KERNEL_ENTRIES-1:0] k_valid_ff;

   // scan datapath
   logic [ADDR_W-1:0] addr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              kphase_ff;
   logic              cand_live_ff;
   logic              cand_vld_ff;
   logic [CNT_W-1:0]  cand_idx_ff;
   logic [ADDR_W-1:0] u_rd_base_ff;
   logic [SIZE_W-1:0] u_rd_size_ff;
   logic [ADDR_W-1:0] k_rd_base_ff;
   logic              found_ff;
   logic [ADDR_W-1:0] best_diff_ff;
   logic [CNT_W-1:0]  best_idx_ff;
   logic [SIZE_W-1:0] best_size_ff;

   // response register
   logic               rsp_valid_ff;
   logic [SRC_W-1:0]   rsp_src_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic [ADDR_W-1:0]  rsp_off_ff;

   logic              req_xfer;
   logic              rsp_xfer;
   logic              rsp_free;
   logic              rsp_load;
   logic [WIDX_W-1:0] wr_idx;
   logic              wr_user;
   logic              wr_kernel;
   logic [CNT_W-1:0]  scan_n;
   logic              issue;
   logic              issue_vld;
   logic [ADDR_W-1:0] cand_base;
   logic [ADDR_W:0]   diff_full;
   logic              cand_better;
   logic              user_hit;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign rsp_xfer     = rsp_valid_ff && rsp_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load     = (state_ff == ST_FINISH) && rsp_free;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.match_source   = rsp_src_ff;
   assign rsp_if.match_index    = rsp_idx_ff;
   assign rsp_if.address_offset = rsp_off_ff;

   assign wr_idx    = WIDX_W'(req_if.entry_index);
   assign wr_user   = req_xfer && (req_if.kind == KIND_WR_USER) &&
                      (int'(req_if.entry_index) < USER_ENTRIES);
   assign wr_kernel = req_xfer && (req_if.kind == KIND_WR_KERNEL) &&
                      (int'(req_if.entry_index) < KERNEL_ENTRIES);

   assign scan_n = kphase_ff ? CNT_W'(KERNEL_ENTRIES) : CNT_W'(USER_ENTRIES);
   assign issue  = (state_ff == ST_SCAN) && (cnt_ff < scan_n);

   always_comb begin
      issue_vld = 1'b0;
      if (issue) begin
         if (kphase_ff) begin
            issue_vld = k_valid_ff[cnt_ff[KIDX_W-1:0]];
         end else begin
            issue_vld = u_valid_ff[cnt_ff[UIDX_W-1:0]];
         end
      end
   end

   // shared unit: address minus candidate base, borrow flags base above address,
   // smaller difference means greater base; ties keep the earlier index
   assign cand_base   = kphase_ff ? k_rd_base_ff : u_rd_base_ff;
   assign diff_full   = {1'b0, addr_ff} - {1'b0, cand_base};
   assign cand_better = cand_live_ff && cand_vld_ff && !diff_full[ADDR_W] &&
                        (!found_ff || (diff_full[ADDR_W-1:0] < best_diff_ff));

   assign user_hit = found_ff &&
                     ((best_size_ff == '0) || (best_diff_ff < ADDR_W'(best_size_ff)));

   always_ff @(posedge clock) begin
      if (wr_user) begin
         u_base_mem[wr_idx[UIDX_W-1:0]] <= req_if.entry_base;
         u_size_mem[wr_idx[UIDX_W-1:0]] <= req_if.entry_size;
      end
      if (issue && !kphase_ff) begin
         u_rd_base_ff <= u_base_mem[cnt_ff[UIDX_W-1:0]];
         u_rd_size_ff <= u_size_mem[cnt_ff[UIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_kernel) begin
         k_base_mem[wr_idx[KIDX_W-1:0]] <= req_if.entry_base;
      end
      if (issue && kphase_ff) begin
         k_rd_base_ff <= k_base_mem[cnt_ff[KIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         u_valid_ff   <= '0;
         k_valid_ff   <= '0;
         cand_live_ff <= 1'b0;
         found_ff     <= 1'b0;
         kphase_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result may be loaded in the cycle the old one transfers
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  case (req_if.kind)
                     KIND_CLR_USER: begin
                        u_valid_ff <= '0;
                     end
                     KIND_CLR_KERNEL: begin
                        k_valid_ff <= '0;
                     end
                     KIND_WR_USER: begin
                        if (wr_user) begin
                           u_valid_ff[wr_idx[UIDX_W-1:0]] <= 1'b1;
                        end
                     end
                     KIND_WR_KERNEL: begin
                        if (wr_kernel) begin
                           k_valid_ff[wr_idx[KIDX_W-1:0]] <= 1'b1;
                        end
                     end
                     KIND_LOOKUP: begin
                        addr_ff      <= req_if.query_address;
                        cnt_ff       <= '0;
                        kphase_ff    <= 1'b0;
                        found_ff     <= 1'b0;
                        cand_live_ff <= 1'b0;
                        state_ff     <= ST_SCAN;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               cand_live_ff <= issue;
               cand_vld_ff  <= issue_vld;
               cand_idx_ff  <= cnt_ff;
               if (issue) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (cand_better) begin
                  found_ff     <= 1'b1;
                  best_diff_ff <= diff_full[ADDR_W-1:0];
                  best_idx_ff  <= cand_idx_ff;
                  if (!kphase_ff) begin
                     best_size_ff <= u_rd_size_ff;
                  end
               end
               // last candidate already compared
               if (!issue && !cand_live_ff) begin
                  state_ff <= kphase_ff ? ST_FINISH : ST_UCHECK;
               end
            end
            ST_UCHECK: begin
               if (user_hit) begin
                  state_ff <= ST_FINISH;
               end else begin
                  found_ff  <= 1'b0;
                  cnt_ff    <= '0;
                  kphase_ff <= 1'b1;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  if (found_ff) begin
                     rsp_src_ff <= kphase_ff ? SRC_KERNEL : SRC_USER;
                     rsp_idx_ff <= INDEX_W'(best_idx_ff);
                     rsp_off_ff <= best_diff_ff;
                  end else begin
                     rsp_src_ff <= SRC_NONE;
                     rsp_idx_ff <= '0;
                     rsp_off_ff <= addr_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ARAT_ASSERT_NEXT(a_finish_loads_rsp, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "no response")
   `ARAT_ASSERT_SAME(a_scan_bound, state_ff == ST_SCAN, cnt_ff <= scan_n, "scan ran past table")
   `ARAT_ASSERT_SAME(a_user_src_index, rsp_valid_ff && (rsp_src_ff == SRC_USER), int'(rsp_idx_ff) < USER_ENTRIES, "bad user index")
   `ARAT_ASSERT_SAME(a_none_index_zero, rsp_valid_ff && (rsp_src_ff == SRC_NONE), rsp_idx_ff == '0, "no-match index set")

endmodule

`default_nettype wire

@@ bench/tb_address_region_attributor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_region_attributor
// drives clears, table writes, lookups and spare kinds into the attributor, keeps its own
// copy of both image tables, and checks every returned attribution in order
// ----------------------------------------------------------------------------
module tb_address_region_attributor;
   import arat_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

   localparam int ITEM_TARGET = 1850;
   localparam int IDLE_LIMIT  = 2500;
   localparam int TAIL_CYCLES = 400;
   localparam int PRINT_CAP   = 40;
   localparam logic [ADDR_W-1:0] WINDOW_MASK = 64'hFFFF_FFFF_FF00_0000;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] entry_index;
      logic [ADDR_W-1:0]  entry_base;
      logic [SIZE_W-1:0]  entry_size;
      logic [ADDR_W-1:0]  query_address;
   } request_type;

   typedef struct packed {
      logic [SRC_W-1:0]   source;
      logic [INDEX_W-1:0] slot;
      logic [ADDR_W-1:0]  offset;
   } attribution_type;

   logic clock;
   logic reset;

   arat_req_if req_ch ();
   arat_rsp_if rsp_ch ();

   address_region_attributor u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // image tables as seen by the bench
   logic [ADDR_W-1:0] user_base   [USER_ENTRIES];
   logic [SIZE_W-1:0] user_size   [USER_ENTRIES];
   bit                user_valid  [USER_ENTRIES];
   logic [ADDR_W-1:0] kernel_base [KERNEL_ENTRIES];
   bit                kernel_valid[KERNEL_ENTRIES];

   attribution_type pending_attributions[$];
   int mismatch_count  = 0;
   int effective_count = 0;
   int burst_left      = 1;
   int ready_run       = 0;
   int idle_cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic flag_mismatch(string what);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // greatest valid base not above the address, lowest slot on equal bases;
   // a user hit outside its extent falls through to the kernel table
   function automatic attribution_type attribute_address(logic [ADDR_W-1:0] addr);
      attribution_type res;
      int ubest;
      int kbest;
      logic [ADDR_W-1:0] off;
      ubest = -1;
      kbest = -1;
      for (int i = 0; i < USER_ENTRIES; i++)
         if (user_valid[i] && user_base[i] <= addr &&
             (ubest < 0 || user_base[i] > user_base[ubest]))
            ubest = i;
      if (ubest >= 0) begin
         off = addr - user_base[ubest];
         if (user_size[ubest] == '0 || off < user_size[ubest]) begin
            res.source = SRC_USER;
            res.slot   = ubest[INDEX_W-1:0];
            res.offset = off;
            return res;
         end
      end
      for (int i = 0; i < KERNEL_ENTRIES; i++)
         if (kernel_valid[i] && kernel_base[i] <= addr &&
             (kbest < 0 || kernel_base[i] > kernel_base[kbest]))
            kbest = i;
      if (kbest >= 0) begin
         res.source = SRC_KERNEL;
         res.slot   = kbest[INDEX_W-1:0];
         res.offset = addr - kernel_base[kbest];
         return res;
      end
      res.source = SRC_NONE;
      res.slot   = '0;
      res.offset = addr;
      return res;
   endfunction

   // apply one accepted transfer to the bench tables
   function automatic void track_request(request_type r);
      case (r.kind)
         KIND_CLR_USER: begin
            foreach (user_valid[i]) user_valid[i] = 1'b0;
            effective_count++;
         end
         KIND_CLR_KERNEL: begin
            foreach (kernel_valid[i]) kernel_valid[i] = 1'b0;
            effective_count++;
         end
         KIND_WR_USER: begin
            if (r.entry_index < USER_ENTRIES) begin
               user_base[r.entry_index]  = r.entry_base;
               user_size[r.entry_index]  = r.entry_size;
               user_valid[r.entry_index] = 1'b1;
               effective_count++;
            end
         end
         KIND_WR_KERNEL: begin
            if (r.entry_index < KERNEL_ENTRIES) begin
               kernel_base[r.entry_index]  = r.entry_base;
               kernel_valid[r.entry_index] = 1'b1;
               effective_count++;
            end
         end
         KIND_LOOKUP: begin
            pending_attributions = {pending_attributions,
                                    attribute_address(r.query_address)};
            effective_count++;
         end
         default: ;
      endcase
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_request(request_type r);
      int gap;
      req_ch.kind          = r.kind;
      req_ch.entry_index   = r.entry_index;
      req_ch.entry_base    = r.entry_base;
      req_ch.entry_size    = r.entry_size;
      req_ch.query_address = r.query_address;
      req_ch.valid         = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      track_request(r);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   function automatic request_type rand_request();
      request_type r;
      r.kind          = KIND_W'($urandom_range(0, KIND_SPARE_C));
      r.entry_index   = INDEX_W'($urandom_range(0, 255));
      r.entry_base    = rand64();
      r.entry_size    = $urandom;
      r.query_address = rand64();
      return r;
   endfunction

   task automatic clear_table(logic [KIND_W-1:0] which);
      request_type r;
      r      = rand_request();
      r.kind = which;
      send_request(r);
   endtask

   task automatic write_user(int slot, logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size);
      request_type r;
      r             = rand_request();
      r.kind        = KIND_WR_USER;
      r.entry_index = slot[INDEX_W-1:0];
      r.entry_base  = base;
      r.entry_size  = size;
      send_request(r);
   endtask

   task automatic write_kernel(int slot, logic [ADDR_W-1:0] base);
      request_type r;
      r             = rand_request();
      r.kind        = KIND_WR_KERNEL;
      r.entry_index = slot[INDEX_W-1:0];
      r.entry_base  = base;
      send_request(r);
   endtask

   task automatic lookup(logic [ADDR_W-1:0] addr);
      request_type r;
      r               = rand_request();
      r.kind          = KIND_LOOKUP;
      r.query_address = addr;
      send_request(r);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         2:       return $urandom;
         default: return $urandom_range(1, 'h4_0000);
      endcase
   endfunction

   // mostly addresses in and around live entries, some just below or past them
   function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] window);
      int slots[$];
      int s;
      int choice;
      logic [ADDR_W-1:0] span;
      choice = $urandom_range(0, 9);
      if (choice < 5) begin
         foreach (user_valid[i]) if (user_valid[i]) slots = {slots, i};
         if (slots.size() > 0) begin
            s = slots[$urandom_range(0, slots.size() - 1)];
            if (choice == 0)
               return user_base[s] - 1;
            span = {{(ADDR_W-SIZE_W){1'b0}}, user_size[s]} + 64'd64;
            return user_base[s] + (rand64() % span);
         end
      end else if (choice < 7) begin
         foreach (kernel_valid[i]) if (kernel_valid[i]) slots = {slots, i};
         if (slots.size() > 0) begin
            s = slots[$urandom_range(0, slots.size() - 1)];
            return kernel_base[s] + $urandom_range(0, 'h1000);
         end
      end else if (choice == 8) begin
         return rand64();
      end else if (choice == 9) begin
         return ($urandom_range(0, 1) == 0) ? '0 : '1;
      end
      return window + $urandom_range(0, 'hFF_FFFF);
   endfunction

   task automatic test_empty_tables();
      lookup('0);
      lookup('1);
   endtask

   task automatic test_user_extents();
      write_user(0, 64'h1000, 32'h100);
      write_user(USER_ENTRIES - 1, 64'hFFFF_FFFF_FFFF_F000, '0);
      // same base as slot 0, lower slot must win
      write_user(5, 64'h1000, 32'h10);
      lookup(64'h1000);
      lookup(64'h10FF);
      lookup(64'h1100);
      lookup('1);
      lookup(64'h0FFF);
      // out of range user slots are dropped
      write_user(USER_ENTRIES, '0, '1);
      write_user(255, '0, '1);
   endtask

   task automatic test_kernel_fallback();
      write_kernel(KERNEL_ENTRIES - 1, 64'h800);
      write_kernel(7, 64'h800);
      write_kernel(0, '0);
      lookup(64'h1100);
      lookup(64'h07FF);
      // rewrite widens slot 0 so the same address now lands in user space
      write_user(0, 64'h1000, '1);
      lookup(64'h1100);
   endtask

   task automatic test_clear_and_spare_kinds();
      clear_table(KIND_SPARE_A);
      clear_table(KIND_SPARE_B);
      clear_table(KIND_SPARE_C);
      clear_table(KIND_CLR_USER);
      lookup(64'h1100);
      clear_table(KIND_CLR_KERNEL);
      lookup(64'h1100);
   endtask

   task automatic test_random_traffic();
      logic [ADDR_W-1:0] window;
      logic [ADDR_W-1:0] last_base;
      logic [ADDR_W-1:0] base;
      int mode;
      int n;
      window    = '0;
      last_base = '0;
      while (effective_count < ITEM_TARGET) begin
         mode = $urandom_range(0, 9);
         if (mode < 7) begin
            case ($urandom_range(0, 3))
               0:       window = rand64() & WINDOW_MASK;
               1:       window = '0;
               2:       window = WINDOW_MASK;
               default: ;
            endcase
            if ($urandom_range(0, 2) == 0) clear_table(KIND_CLR_USER);
            if ($urandom_range(0, 2) == 0) clear_table(KIND_CLR_KERNEL);
            n = $urandom_range(1, 8);
            repeat (n) begin
               // occasional repeated base to exercise tie breaking
               base = ($urandom_range(0, 5) == 0) ? last_base
                                                  : window + $urandom_range(0, 'hFF_FFFF);
               last_base = base;
               write_user($urandom_range(0, USER_ENTRIES - 1), base, pick_size());
            end
            n = $urandom_range(0, 6);
            repeat (n) begin
               base = ($urandom_range(0, 5) == 0) ? last_base
                                                  : window + $urandom_range(0, 'hFF_FFFF);
               write_kernel($urandom_range(0, KERNEL_ENTRIES - 1), base);
            end
            n = $urandom_range(2, 10);
            repeat (n) lookup(pick_address(window));
         end else if (mode < 9) begin
            n = $urandom_range(1, 6);
            repeat (n) lookup(pick_address(window));
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_request(rand_request());
         end
      end
   endtask

   // response side stalls in runs of its own
   always @(negedge clock) begin
      if (ready_run > 0) begin
         ready_run--;
      end else if (rsp_ch.ready) begin
         rsp_ch.ready = 1'b0;
         ready_run    = $urandom_range(0, 23);
      end else begin
         rsp_ch.ready = 1'b1;
         ready_run    = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(0, 30);
      end
   end

   always @(posedge clock) begin : check_results
      attribution_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_attributions.size() == 0) begin
            flag_mismatch("result transfer with no lookup outstanding");
         end else begin
            want = pending_attributions.pop_front();
            if (rsp_ch.match_source !== want.source)
               flag_mismatch($sformatf("match_source %0d, expected %0d",
                                       rsp_ch.match_source, want.source));
            if (rsp_ch.match_index !== want.slot)
               flag_mismatch($sformatf("match_index %0d, expected %0d",
                                       rsp_ch.match_index, want.slot));
            if (rsp_ch.address_offset !== want.offset)
               flag_mismatch($sformatf("address_offset %h, expected %h",
                                       rsp_ch.address_offset, want.offset));
         end
      end
   end

   // any cycle without a transfer on either channel counts toward the limit
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("address_region_attributor test failed");
            $finish;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.kind          = '0;
      req_ch.entry_index   = '0;
      req_ch.entry_base    = '0;
      req_ch.entry_size    = '0;
      req_ch.query_address = '0;
      rsp_ch.ready         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_tables();
      test_user_extents();
      test_kernel_fallback();
      test_clear_and_spare_kinds();
      test_random_traffic();

      req_ch.valid = 1'b0;
      while (pending_attributions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_attributions.size() != 0)
         flag_mismatch("lookups left without a result");

      if (mismatch_count == 0) begin
         $display("address_region_attributor test passed");
      end else begin
         $display("address_region_attributor test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/arat_pkg.sv
hw/rtl/arat_if.sv
hw/rtl/address_region_attributor.sv
bench/tb_address_region_attributor.sv
